// ===== design/msadp_pkg.sv =====
// Shared types, constants and coefficient tables of the stereo ADPCM block decoder.
package msadp_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int BYTE_W            = 8;
  localparam int ALIGN_W           = 13;
  localparam int STEP_W            = 24;
  localparam int COEF_W            = 11;
  localparam int CSEL_W            = 3;
  localparam int NIB_W             = 4;
  localparam int HPOS_W            = 4;

  localparam int DEF_MAX_BLOCK_BYTES = 4096;
  localparam int HEADER_BYTES        = 14;
  localparam int ALIGN_RESET         = 2048;
  localparam int STEP_FLOOR          = 16;
  localparam int STEP_CEIL           = 8388607;
  localparam int SAMPLE_MAX          = 32767;
  localparam int SAMPLE_MIN          = -32768;
  localparam int RESULTS_MAX         = 4;

  localparam logic [CSEL_W-1:0] CSEL_MAX = 3'd6;

  localparam logic [HPOS_W-1:0] HPOS_IDX_L   = 4'd0;
  localparam logic [HPOS_W-1:0] HPOS_IDX_R   = 4'd1;
  localparam logic [HPOS_W-1:0] HPOS_STEP_L  = 4'd3;
  localparam logic [HPOS_W-1:0] HPOS_STEP_R  = 4'd5;
  localparam logic [HPOS_W-1:0] HPOS_PREV_L  = 4'd7;
  localparam logic [HPOS_W-1:0] HPOS_PREV_R  = 4'd9;
  localparam logic [HPOS_W-1:0] HPOS_OLDER_L = 4'd11;
  localparam logic [HPOS_W-1:0] HPOS_OLDER_R = 4'd13;

  typedef struct packed {
    logic                     coef_we;
    logic [CSEL_W-1:0]        coef_val;
    logic                     step_we;
    logic                     prev_we;
    logic                     older_we;
    logic [SAMPLE_W-1:0]      word;
    logic                     mul_en;
    logic [NIB_W-1:0]         nib;
    logic                     commit;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pcm_sample;
    logic                       channel;
    logic                       last;
    logic                       block_end;
    logic                       bad_index;
  } result_t;

  function automatic logic signed [COEF_W-1:0] adapt_factor(input logic [NIB_W-1:0] nib);
    logic signed [COEF_W-1:0] f;
    unique case (nib)
      4'd4, 4'd12: f = 11'sd307;
      4'd5, 4'd11: f = 11'sd409;
      4'd6, 4'd10: f = 11'sd512;
      4'd7, 4'd9:  f = 11'sd614;
      4'd8:        f = 11'sd768;
      default:     f = 11'sd230;
    endcase
    return f;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_one(input logic [CSEL_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    unique case (idx)
      3'd0:    c = 11'sd256;
      3'd1:    c = 11'sd512;
      3'd2:    c = 11'sd0;
      3'd3:    c = 11'sd192;
      3'd4:    c = 11'sd240;
      3'd5:    c = 11'sd460;
      default: c = 11'sd392;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_two(input logic [CSEL_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    unique case (idx)
      3'd0:    c = 11'sd0;
      3'd1:    c = -11'sd256;
      3'd2:    c = 11'sd0;
      3'd3:    c = 11'sd64;
      3'd4:    c = 11'sd0;
      3'd5:    c = -11'sd208;
      default: c = -11'sd232;
    endcase
    return c;
  endfunction

endpackage

// ===== design/msadp_ifs.sv =====
// Valid/ready channel interfaces for byte input, sample output and configuration.
interface msadp_in_if;
  logic                             valid;
  logic                             ready;
  logic [msadp_pkg::BYTE_W-1:0]     code_byte;
  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

interface msadp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [msadp_pkg::SAMPLE_W-1:0] pcm_sample;
  logic                                channel;
  logic                                last;
  logic                                block_end;
  logic                                bad_index;
  modport source (output valid, output pcm_sample, output channel, output last,
                  output block_end, output bad_index, input ready);
  modport sink (input valid, input pcm_sample, input channel, input last,
                input block_end, input bad_index, output ready);
endinterface

interface msadp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [msadp_pkg::ALIGN_W-1:0]     block_align;
  modport source (output valid, output block_align, input ready);
  modport sink (input valid, input block_align, output ready);
endinterface

// ===== design/msadp_lane.sv =====
// One channel decode lane: predictor state, registered products and commit arithmetic.
module msadp_lane (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  msadp_pkg::lane_ctl_t                   ctl,
  output logic signed [msadp_pkg::SAMPLE_W-1:0]  prev_o,
  output logic signed [msadp_pkg::SAMPLE_W-1:0]  older_o,
  output logic signed [msadp_pkg::SAMPLE_W-1:0]  pred_o
);

  logic [msadp_pkg::CSEL_W-1:0]          coef_r;
  logic signed [msadp_pkg::STEP_W-1:0]   step_r,  step_nxt;
  logic signed [msadp_pkg::SAMPLE_W-1:0] prev_r,  prev_nxt;
  logic signed [msadp_pkg::SAMPLE_W-1:0] older_r, older_nxt;

  logic signed [26:0] p1_r, p1_nxt;
  logic signed [26:0] p2_r, p2_nxt;
  logic signed [27:0] p3_r, p3_nxt;
  logic signed [34:0] p4_r, p4_nxt;

  logic signed [msadp_pkg::NIB_W-1:0]  sn;
  logic signed [msadp_pkg::COEF_W-1:0] c1, c2, fac;

  logic signed [27:0] sum12, sum_adj;
  logic signed [19:0] quo;
  logic signed [28:0] pred_full;
  logic signed [34:0] st_adj;
  logic signed [26:0] st_quo;
  logic signed [msadp_pkg::STEP_W-1:0] step_new;

  assign sn  = $signed(ctl.nib);
  assign c1  = msadp_pkg::coef_one(coef_r);
  assign c2  = msadp_pkg::coef_two(coef_r);
  assign fac = msadp_pkg::adapt_factor(ctl.nib);

  always_comb begin
    p1_nxt = p1_r;
    p2_nxt = p2_r;
    p3_nxt = p3_r;
    p4_nxt = p4_r;
    if (ctl.mul_en) begin
      p1_nxt = 27'(prev_r) * 27'(c1);
      p2_nxt = 27'(older_r) * 27'(c2);
      p3_nxt = 28'(sn) * 28'(step_r);
      p4_nxt = 35'(fac) * 35'(step_r);
    end
  end

  always_comb begin
    sum12     = 28'(p1_r) + 28'(p2_r);
    sum_adj   = sum12 + (sum12[27] ? 28'sd255 : 28'sd0);
    quo       = $signed(sum_adj[27:8]);
    pred_full = 29'(quo) + 29'(p3_r);
    if (pred_full > 29'(msadp_pkg::SAMPLE_MAX)) begin
      pred_o = 16'(msadp_pkg::SAMPLE_MAX);
    end else if (pred_full < 29'(msadp_pkg::SAMPLE_MIN)) begin
      pred_o = 16'(msadp_pkg::SAMPLE_MIN);
    end else begin
      pred_o = pred_full[15:0];
    end
    st_adj = p4_r + (p4_r[34] ? 35'sd255 : 35'sd0);
    st_quo = $signed(st_adj[34:8]);
    if (st_quo < 27'(msadp_pkg::STEP_FLOOR)) begin
      step_new = 24'(msadp_pkg::STEP_FLOOR);
    end else if (st_quo > 27'(msadp_pkg::STEP_CEIL)) begin
      step_new = 24'(msadp_pkg::STEP_CEIL);
    end else begin
      step_new = st_quo[23:0];
    end
  end

  always_comb begin
    step_nxt  = step_r;
    prev_nxt  = prev_r;
    older_nxt = older_r;
    if (ctl.commit) begin
      step_nxt  = step_new;
      prev_nxt  = pred_o;
      older_nxt = prev_r;
    end
    if (ctl.step_we) begin
      step_nxt = 24'($signed(ctl.word));
    end
    if (ctl.prev_we) begin
      prev_nxt = $signed(ctl.word);
    end
    if (ctl.older_we) begin
      older_nxt = $signed(ctl.word);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r  <= '0;
      step_r  <= '0;
      prev_r  <= '0;
      older_r <= '0;
    end else begin
      if (ctl.coef_we) begin
        coef_r <= ctl.coef_val;
      end
      step_r  <= step_nxt;
      prev_r  <= prev_nxt;
      older_r <= older_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
    p3_r <= p3_nxt;
    p4_r <= p4_nxt;
  end

  assign prev_o  = prev_r;
  assign older_o = older_r;

endmodule

// ===== design/msadp_merge.sv =====
// Result merge stage: four-slot shift buffer that orders lane results onto the output channel.
module msadp_merge (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             load,
  input  logic                                             four,
  input  msadp_pkg::result_t [msadp_pkg::RESULTS_MAX-1:0]  ent,
  output logic                                             can_load,
  msadp_out_if.source                                      out_ch
);

  localparam int CNT_W = $clog2(msadp_pkg::RESULTS_MAX + 1);

  msadp_pkg::result_t [msadp_pkg::RESULTS_MAX-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fire;

  assign fire     = out_ch.valid && out_ch.ready;
  assign can_load = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && fire);

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      slot_nxt = ent;
      cnt_nxt  = four ? CNT_W'(msadp_pkg::RESULTS_MAX) : CNT_W'(2);
    end else if (fire) begin
      for (int i = 0; i < msadp_pkg::RESULTS_MAX - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.pcm_sample = slot_r[0].pcm_sample;
  assign out_ch.channel    = slot_r[0].channel;
  assign out_ch.last       = slot_r[0].last;
  assign out_ch.block_end  = slot_r[0].block_end;
  assign out_ch.bad_index  = slot_r[0].bad_index;

endmodule

// ===== design/ms_adpcm_stereo_decoder_top.sv =====
// Stereo ADPCM block decoder top: header parsing, two channel lanes and result merge.
// Flow: a data byte's lane products are registered, then its left and right samples go
//   to the merge buffer, offered left first; header byte 13 gives its four samples there.
// Input: no byte is taken until the lane stage has handed its byte to the merge, when the
//   lanes commit predictor state; else header bytes 0 to 12 are taken one per cycle.
// Reset: synchronous, clears each lane's predictor state and the block position, block_align to 2048.
module ms_adpcm_stereo_decoder_top #(
  parameter int MAX_BLOCK_BYTES = msadp_pkg::DEF_MAX_BLOCK_BYTES
) (
  input  logic          clk,
  input  logic          rst_n,
  msadp_in_if.sink      in_ch,
  msadp_cfg_if.sink     cfg_ch,
  msadp_out_if.source   out_ch
);

  localparam int POS_W = $clog2(MAX_BLOCK_BYTES);
  localparam int LEN_W = ($clog2(MAX_BLOCK_BYTES + 1) > msadp_pkg::ALIGN_W) ?
                         $clog2(MAX_BLOCK_BYTES + 1) : msadp_pkg::ALIGN_W;

  logic [msadp_pkg::ALIGN_W-1:0] align_r;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [msadp_pkg::BYTE_W-1:0]  hlow_r, hlow_nxt;
  logic                          idx_err_r, idx_err_nxt;
  logic                          s1_valid_r, s1_valid_nxt;
  logic                          s1_data_r, s1_data_nxt;
  logic                          s1_final_r, s1_final_nxt;

  logic [LEN_W-1:0]              align_ext, len_c, pos_ext;
  logic                          in_fire, is_data, is_final, bad_byte;
  logic [msadp_pkg::HPOS_W-1:0]  hdr_pos;
  logic [msadp_pkg::BYTE_W-1:0]  b;
  logic [msadp_pkg::CSEL_W-1:0]  csel;
  logic [msadp_pkg::SAMPLE_W-1:0] word;

  msadp_pkg::lane_ctl_t ctl_l, ctl_r;
  logic signed [msadp_pkg::SAMPLE_W-1:0] prev_l, older_l, pred_l;
  logic signed [msadp_pkg::SAMPLE_W-1:0] prev_rc, older_rc, pred_rc;

  msadp_pkg::result_t [msadp_pkg::RESULTS_MAX-1:0] ent;
  logic mg_can_load, mg_load;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !s1_valid_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign b            = in_ch.code_byte;

  assign align_ext = LEN_W'(align_r);
  assign pos_ext   = LEN_W'(pos_r);
  assign hdr_pos   = pos_r[msadp_pkg::HPOS_W-1:0];
  assign is_data   = pos_ext >= LEN_W'(msadp_pkg::HEADER_BYTES);
  assign bad_byte  = b > 8'(msadp_pkg::CSEL_MAX);
  assign csel      = bad_byte ? msadp_pkg::CSEL_MAX : b[msadp_pkg::CSEL_W-1:0];
  assign word      = {b, hlow_r};

  always_comb begin
    if (align_ext < LEN_W'(msadp_pkg::HEADER_BYTES)) begin
      len_c = LEN_W'(msadp_pkg::HEADER_BYTES);
    end else if (align_ext > LEN_W'(MAX_BLOCK_BYTES)) begin
      len_c = LEN_W'(MAX_BLOCK_BYTES);
    end else begin
      len_c = align_ext;
    end
  end

  assign is_final = (pos_ext + LEN_W'(1)) >= len_c;
  assign mg_load  = s1_valid_r && mg_can_load;

  always_comb begin
    ctl_l        = '0;
    ctl_r        = '0;
    ctl_l.word   = word;
    ctl_r.word   = word;
    ctl_l.coef_val = csel;
    ctl_r.coef_val = csel;
    ctl_l.nib    = b[7:4];
    ctl_r.nib    = b[3:0];
    hlow_nxt     = hlow_r;
    idx_err_nxt  = idx_err_r;
    pos_nxt      = pos_r;
    s1_valid_nxt = s1_valid_r && !mg_load;
    s1_data_nxt  = s1_data_r;
    s1_final_nxt = s1_final_r;

    ctl_l.commit = mg_load && s1_data_r;
    ctl_r.commit = mg_load && s1_data_r;

    if (in_fire) begin
      pos_nxt      = is_final ? '0 : POS_W'(pos_ext + LEN_W'(1));
      s1_final_nxt = is_final;
      if (is_data) begin
        ctl_l.mul_en = 1'b1;
        ctl_r.mul_en = 1'b1;
        s1_valid_nxt = 1'b1;
        s1_data_nxt  = 1'b1;
      end else begin
        unique case (hdr_pos)
          msadp_pkg::HPOS_IDX_L: begin
            idx_err_nxt   = bad_byte;
            ctl_l.coef_we = 1'b1;
          end
          msadp_pkg::HPOS_IDX_R: begin
            idx_err_nxt   = idx_err_r || bad_byte;
            ctl_r.coef_we = 1'b1;
          end
          msadp_pkg::HPOS_STEP_L:  ctl_l.step_we  = 1'b1;
          msadp_pkg::HPOS_STEP_R:  ctl_r.step_we  = 1'b1;
          msadp_pkg::HPOS_PREV_L:  ctl_l.prev_we  = 1'b1;
          msadp_pkg::HPOS_PREV_R:  ctl_r.prev_we  = 1'b1;
          msadp_pkg::HPOS_OLDER_L: ctl_l.older_we = 1'b1;
          msadp_pkg::HPOS_OLDER_R: begin
            ctl_r.older_we = 1'b1;
            s1_valid_nxt   = 1'b1;
            s1_data_nxt    = 1'b0;
          end
          default: hlow_nxt = b;
        endcase
      end
    end
  end

  always_comb begin
    if (s1_data_r) begin
      ent[0] = '{pcm_sample: pred_l,  channel: 1'b0, last: 1'b0, block_end: 1'b0,
                 bad_index: idx_err_r};
      ent[1] = '{pcm_sample: pred_rc, channel: 1'b1, last: 1'b1, block_end: s1_final_r,
                 bad_index: idx_err_r};
      ent[2] = ent[1];
      ent[3] = ent[1];
    end else begin
      ent[0] = '{pcm_sample: older_l,  channel: 1'b0, last: 1'b0, block_end: 1'b0,
                 bad_index: idx_err_r};
      ent[1] = '{pcm_sample: older_rc, channel: 1'b1, last: 1'b0, block_end: 1'b0,
                 bad_index: idx_err_r};
      ent[2] = '{pcm_sample: prev_l,   channel: 1'b0, last: 1'b0, block_end: 1'b0,
                 bad_index: idx_err_r};
      ent[3] = '{pcm_sample: prev_rc,  channel: 1'b1, last: 1'b1, block_end: s1_final_r,
                 bad_index: idx_err_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r    <= msadp_pkg::ALIGN_W'(msadp_pkg::ALIGN_RESET);
      pos_r      <= '0;
      hlow_r     <= '0;
      idx_err_r  <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        align_r <= cfg_ch.block_align;
      end
      pos_r      <= pos_nxt;
      hlow_r     <= hlow_nxt;
      idx_err_r  <= idx_err_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r  <= s1_data_nxt;
    s1_final_r <= s1_final_nxt;
  end

  msadp_lane u_lane_l (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_l),
    .prev_o  (prev_l),
    .older_o (older_l),
    .pred_o  (pred_l)
  );

  msadp_lane u_lane_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_r),
    .prev_o  (prev_rc),
    .older_o (older_rc),
    .pred_o  (pred_rc)
  );

  msadp_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (mg_load),
    .four     (!s1_data_r),
    .ent      (ent),
    .can_load (mg_can_load),
    .out_ch   (out_ch)
  );

  a_data_enters_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_data |=> s1_valid_r && s1_data_r)
    else $error("data transaction did not reach the lane stage");

  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    mg_load |=> !s1_valid_r)
    else $error("lane stage held after hand-over to merge");

  a_block_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.block_end |-> out_ch.last)
    else $error("block end on a result that is not the last of its byte");

  a_left_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.channel |-> !out_ch.last)
    else $error("left sample flagged as last");

endmodule
